/* hw/rtl/ssg_pkg.sv */
`default_nettype none

package ssg_pkg;

    localparam int MAX_GROUPS    = 64;
    localparam int GRP_W         = $clog2(MAX_GROUPS);
    localparam int GRP_CNT_W     = $clog2(MAX_GROUPS + 1);
    localparam int ENTRY_BITS    = 32;
    localparam int FRACTION_BITS = 16;
    localparam int SUM_W         = ENTRY_BITS + GRP_W;
    localparam int PROD_W        = SUM_W + FRACTION_BITS;
    localparam int MAT_AW        = 2 * GRP_W;
    localparam int MAT_DEPTH     = MAX_GROUPS * MAX_GROUPS;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_DATA = 2'd1;
    localparam logic [1:0] ST_BAD     = 2'd2;

    localparam logic [1:0] CMD_WRITE  = 2'd0;
    localparam logic [1:0] CMD_SAMPLE = 2'd1;
    localparam logic [1:0] CMD_BAD    = 2'd2;

    typedef struct packed {
        logic        action;
        logic [5:0]  from_group;
        logic [5:0]  to_group;
        logic [31:0] entry_value;
        logic [15:0] random_fraction;
        logic        adjoint;
    } t_in_item;

    typedef struct packed {
        logic [5:0] sampled_group;
        logic [1:0] status;
    } t_out_item;

    typedef struct packed {
        logic [1:0]               kind;
        logic [GRP_W-1:0]         row;
        logic [GRP_W-1:0]         col;
        logic [ENTRY_BITS-1:0]    value;
        logic [FRACTION_BITS-1:0] frac;
        logic                     adj;
    } t_cmd;

endpackage

`default_nettype wire

/* hw/rtl/ssg_front.sv */
`default_nettype none

module ssg_front import ssg_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [GRP_CNT_W-1:0] i_groups,
    input  wire logic                 i_push,
    input  wire t_in_item             i_item,
    output logic                      o_full,
    input  wire logic                 i_cmd_pop,
    output logic                      o_cmd_avail,
    output t_cmd                      o_cmd
);

    t_cmd              w_cmd;
    logic              w_push;
    logic              w_pop;
    t_cmd              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QCNT_W-1:0] n_count;

    always_comb begin
        w_cmd.row   = i_item.from_group[GRP_W-1:0];
        w_cmd.col   = i_item.to_group[GRP_W-1:0];
        w_cmd.value = i_item.entry_value[ENTRY_BITS-1:0];
        w_cmd.frac  = i_item.random_fraction[FRACTION_BITS-1:0];
        w_cmd.adj   = i_item.adjoint;
        if (i_item.action == ACT_WRITE) begin
            w_cmd.kind = CMD_WRITE;
        end else if ({1'b0, i_item.from_group} >= i_groups) begin
            w_cmd.kind = CMD_BAD;
        end else begin
            w_cmd.kind = CMD_SAMPLE;
        end
    end

    assign o_full      = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_cmd_avail = (r_count != '0);
    assign o_cmd       = r_q[r_rd_ptr];
    assign w_push      = i_push && !o_full;
    assign w_pop       = i_cmd_pop && o_cmd_avail;

    always_comb begin
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (!w_push && w_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_cmd;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/ssg_back.sv */
`default_nettype none

module ssg_back import ssg_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [GRP_CNT_W-1:0] i_groups,
    input  wire logic                 i_cmd_avail,
    input  wire t_cmd                 i_cmd,
    output logic                      o_cmd_pop,
    input  wire logic                 i_pop,
    output logic                      o_empty,
    output t_out_item                 o_item
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SUM  = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_WALK = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [ENTRY_BITS-1:0]    r_mem [MAT_DEPTH];
    logic [ENTRY_BITS-1:0]    r_mem_q;
    logic [2:0]               r_state;
    logic [2:0]               n_state;
    t_cmd                     r_cmd;
    logic [GRP_CNT_W-1:0]     r_g;
    logic [GRP_CNT_W-1:0]     n_g;
    logic                     r_issue;
    logic                     n_issue;
    logic                     r_rd_valid;
    logic                     r_rd_last;
    logic [GRP_W-1:0]         r_rd_grp;
    logic [SUM_W-1:0]         r_total;
    logic [SUM_W-1:0]         r_run;
    logic [PROD_W-1:0]        r_prod;
    t_out_item                r_res;
    t_out_item                n_res;
    logic                     r_out_valid;
    t_out_item                r_out;
    logic                     w_we;
    logic [MAT_AW-1:0]        w_waddr;
    logic [MAT_AW-1:0]        w_raddr;
    logic                     w_issue_last;
    logic [SUM_W-1:0]         w_q_ext;
    logic [SUM_W-1:0]         w_total;
    logic [SUM_W-1:0]         w_run;
    logic [PROD_W-1:0]        w_prod;
    logic                     w_hit;
    logic                     w_load_out;

    assign w_we    = (r_state == S_IDLE) && i_cmd_avail && (i_cmd.kind == CMD_WRITE);
    assign w_waddr = {i_cmd.row, i_cmd.col};
    assign w_raddr = r_cmd.adj ? {r_g[GRP_W-1:0], r_cmd.row} : {r_cmd.row, r_g[GRP_W-1:0]};

    assign w_issue_last = (r_g == (i_groups - 1'b1));
    assign w_q_ext      = {{(SUM_W - ENTRY_BITS){1'b0}}, r_mem_q};
    assign w_total      = r_total + w_q_ext;
    assign w_run        = r_run + w_q_ext;
    assign w_prod       = r_total * r_cmd.frac;
    assign w_hit        = ({w_run, {FRACTION_BITS{1'b0}}} >= r_prod);
    assign w_load_out   = (r_state == S_EMIT) && !r_out_valid;

    assign o_empty = !r_out_valid;
    assign o_item  = r_out;

    always_comb begin
        n_state   = r_state;
        n_issue   = r_issue;
        n_g       = r_g;
        n_res     = r_res;
        o_cmd_pop = 1'b0;
        if (r_issue) begin
            n_g = r_g + 1'b1;
            if (w_issue_last) begin
                n_issue = 1'b0;
            end
        end
        case (r_state)
            S_IDLE: begin
                if (i_cmd_avail) begin
                    o_cmd_pop = 1'b1;
                    case (i_cmd.kind)
                        CMD_SAMPLE: begin
                            n_state = S_SUM;
                            n_issue = 1'b1;
                            n_g     = '0;
                        end
                        CMD_BAD: begin
                            n_res.sampled_group = '0;
                            n_res.status        = ST_BAD;
                            n_state             = S_EMIT;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SUM: begin
                if (r_rd_valid && r_rd_last) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                if (r_total == '0) begin
                    n_res.sampled_group = 6'(r_cmd.row);
                    n_res.status        = ST_NO_DATA;
                    n_state             = S_EMIT;
                end else begin
                    n_state = S_WALK;
                    n_issue = 1'b1;
                    n_g     = '0;
                end
            end
            S_WALK: begin
                if (r_rd_valid && (w_hit || r_rd_last)) begin
                    n_res.sampled_group = 6'(r_rd_grp);
                    n_res.status        = ST_OK;
                    n_issue             = 1'b0;
                    n_state             = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_out_valid) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= i_cmd.value;
        end
        r_mem_q <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issue     <= 1'b0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_issue    <= n_issue;
            r_rd_valid <= r_issue;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_g       <= n_g;
        r_res     <= n_res;
        r_rd_grp  <= r_g[GRP_W-1:0];
        r_rd_last <= w_issue_last;
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
        if (r_state == S_IDLE) begin
            r_total <= '0;
        end else if ((r_state == S_SUM) && r_rd_valid) begin
            r_total <= w_total;
        end
        if (r_state == S_MUL) begin
            r_run  <= '0;
            r_prod <= w_prod;
        end else if ((r_state == S_WALK) && r_rd_valid) begin
            r_run <= w_run;
        end
        if (w_load_out) begin
            r_out <= r_res;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/scatter_group_sampler.sv */
// Group sampler over a square transfer matrix held in on-chip memory.
// Input side is a queue: drive i_item and raise i_push; the transfer
// happens when i_push is high and o_full is low. A write item stores one
// matrix entry; a sample item returns one result. Load every entry used by
// a sample before issuing it.
// Result side is a queue: while o_empty is low o_item holds the oldest
// result; raise i_pop to transfer it. A stalled result holds; the engine
// finishes one more result, then up to four more items queue on the input
// side before o_full rises.
// Configuration: i_cfg_data sets the group count N on a transfer of
// i_cfg_valid and o_cfg_ready (always ready). Change it only while idle.
// Operation: a sample makes one row or column pass over the matrix to form
// the total, a multiply, then one pass to find the group, reading one entry
// at a time through the single read port of the matrix memory. The engine
// takes no new item until the last result has moved to the result side. A
// write is stored while the engine is idle; a bad-source sample skips the
// matrix reads and returns group 0.
// Reset clears the queues and sets N to 64; matrix contents are kept.

`default_nettype none

module scatter_group_sampler import ssg_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  wire t_in_item i_item,
    output logic          o_full,
    input  wire logic     i_pop,
    output logic          o_empty,
    output t_out_item     o_item,
    input  wire logic     i_cfg_valid,
    input  wire logic [6:0] i_cfg_data,
    output logic          o_cfg_ready
);

    logic [GRP_CNT_W-1:0] r_grp_cnt;
    logic [GRP_CNT_W-1:0] n_grp_cnt;
    logic                 w_cmd_avail;
    logic                 w_cmd_pop;
    t_cmd                 w_cmd;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        if (i_cfg_data == '0) begin
            n_grp_cnt = GRP_CNT_W'(1);
        end else if (32'(i_cfg_data) > MAX_GROUPS) begin
            n_grp_cnt = GRP_CNT_W'(MAX_GROUPS);
        end else begin
            n_grp_cnt = GRP_CNT_W'(i_cfg_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grp_cnt <= GRP_CNT_W'(MAX_GROUPS);
        end else if (i_cfg_valid) begin
            r_grp_cnt <= n_grp_cnt;
        end
    end

    ssg_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_groups    (r_grp_cnt),
        .i_push      (i_push),
        .i_item      (i_item),
        .o_full      (o_full),
        .i_cmd_pop   (w_cmd_pop),
        .o_cmd_avail (w_cmd_avail),
        .o_cmd       (w_cmd)
    );

    ssg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_groups    (r_grp_cnt),
        .i_cmd_avail (w_cmd_avail),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_item      (o_item)
    );

endmodule

`default_nettype wire

/* hw/rtl/ssg_checker.sv */
`default_nettype none

module ssg_checker import ssg_pkg::*; (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_full,
    input wire logic      i_pop,
    input wire logic      i_empty,
    input wire t_out_item i_item
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> i_empty && !i_full)
        else $error("queues not cleared by reset");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_empty && !i_pop |=> !i_empty && $stable(i_item))
        else $error("stalled result changed");

    a_bad_group_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_empty && (i_item.status == ST_BAD) |-> (i_item.sampled_group == '0))
        else $error("bad source result with nonzero group");

endmodule

bind scatter_group_sampler ssg_checker u_ssg_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_full  (o_full),
    .i_pop   (i_pop),
    .i_empty (o_empty),
    .i_item  (o_item)
);

`default_nettype wire
